// File: src/lkec_pkg.sv
// Package for the keyed LRU entry cache: field widths, payload types and operation codes.
// No dependencies; imported by lru_keyed_entry_cache_core.
`default_nettype none

package lkec_pkg;

  localparam int unsigned KEY_W    = 64;
  localparam int unsigned STAMP_W  = 64;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned DIM_W    = 16;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned SLOT_W   = 3;

  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [STAMP_W-1:0]  stamp_t;
  typedef logic [LEN_W-1:0]    len_t;
  typedef logic [DIM_W-1:0]    dim_t;
  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [SLOT_W-1:0]   slot_t;

  // Operation codes carried on the kind field.
  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_STORE  = 1'b1;

endpackage

`default_nettype wire

// File: src/lru_keyed_entry_cache_core.sv
// Fully associative cache with timestamp LRU replacement, scanned one entry per cycle.
// Depends on lkec_pkg for field widths, payload types and operation codes.
//
//  Channel   | Direction | Handshake                         | Payload
//  ----------+-----------+-----------------------------------+-----------------------------------
//  request   | in        | accepted when start && !busy      | kind, entry_key, new_seq_len,
//            |           |                                   | new_dim, new_handle
//  result    | out       | result_valid_o high for one cycle | success, slot_index, found_seq_len,
//            |           |                                   | found_dim, found_handle
//  config    | in        | written when cfg_valid_i && ready | cfg_data_i (cache_enabled)
//
// Cycles: a request that bypasses the cache (cache disabled, or a store with zero length or
// dimension) gives its result in the cycle after acceptance. Otherwise the entry memories are
// read through one port, one entry per cycle, and compared in the next cycle. A hit, or for
// a store a free entry, ends the scan; a lookup miss answers once the last entry is compared,
// and a store that finds neither evicts the oldest entry after comparing every entry.
// Reset clears the valid bits, the tick counter and the sequencer; the entry memories hold no
// reset value and are only read behind a valid bit. The receiver cannot stall: each result
// sits on the ports for exactly one cycle, and busy falls in that same cycle.
`default_nettype none

module lru_keyed_entry_cache_core #(
  parameter int unsigned ENTRIES = 8
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  // Request channel.
  input  wire                  start,
  output logic                 busy,
  input  wire                  kind_i,
  input  lkec_pkg::key_t       entry_key_i,
  input  lkec_pkg::len_t       new_seq_len_i,
  input  lkec_pkg::dim_t       new_dim_i,
  input  lkec_pkg::handle_t    new_handle_i,
  // Result channel.
  output logic                 result_valid_o,
  output logic                 success_o,
  output lkec_pkg::slot_t      slot_index_o,
  output lkec_pkg::len_t       found_seq_len_o,
  output lkec_pkg::dim_t       found_dim_o,
  output lkec_pkg::handle_t    found_handle_o,
  // Configuration channel.
  input  wire                  cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire                  cfg_data_i
);

  import lkec_pkg::*;

  // Entry index width, and a scan pointer wide enough to hold ENTRIES itself.
  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] PTR_END  = CNT_W'(ENTRIES);

  // Sequencer codes.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;

  // Control state.
  logic [1:0]       state_q, state_d;
  logic             enabled_q;
  stamp_t           tick_q;
  logic             valid_q [ENTRIES];
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic             res_vld_q, res_vld_d;

  // Latched request.
  logic    req_kind_q;
  key_t    req_key_q;
  len_t    req_len_q;
  dim_t    req_dim_q;
  handle_t req_handle_q;

  // Scan bookkeeping.
  logic [IDX_W-1:0] cmp_idx_q;
  logic [IDX_W-1:0] tgt_q, tgt_d;
  stamp_t           oldest_q, oldest_d;

  // Entry memories and their registered read data.
  key_t    key_mem    [ENTRIES];
  stamp_t  stamp_mem  [ENTRIES];
  len_t    len_mem    [ENTRIES];
  dim_t    dim_mem    [ENTRIES];
  handle_t handle_mem [ENTRIES];

  key_t    key_rd_q;
  stamp_t  stamp_rd_q;
  len_t    len_rd_q;
  dim_t    dim_rd_q;
  handle_t handle_rd_q;
  logic    vld_rd_q;

  // Result registers.
  logic    success_q, success_d;
  slot_t   slot_q, slot_d;
  len_t    found_len_q;
  dim_t    found_dim_q;
  handle_t found_handle_q;
  logic    found_load;

  logic             accept;
  logic             bypass;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             key_hit;
  logic             free_or_hit;
  logic             older;
  logic [IDX_W-1:0] cand_idx;
  stamp_t           cand_stamp;
  logic             do_write;
  stamp_t           tick_next;

  assign accept    = start && !busy;
  assign busy      = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // A disabled cache or a store with no payload size answers with an all-zero result at once.
  assign bypass = !enabled_q ||
                  ((kind_i == KIND_STORE) && ((new_seq_len_i == '0) || (new_dim_i == '0)));

  assign rd_en   = (state_q == S_SCAN) && (ptr_q < PTR_END);
  assign rd_addr = ptr_q[IDX_W-1:0];

  // Compare stage: the one shared key comparator and the one stamp comparator.
  assign key_hit     = vld_rd_q && (key_rd_q == req_key_q);
  assign free_or_hit = !vld_rd_q || (key_rd_q == req_key_q);
  assign older       = (cmp_idx_q == '0) || (stamp_rd_q < oldest_q);
  assign cand_idx    = older ? cmp_idx_q  : tgt_q;
  assign cand_stamp  = older ? stamp_rd_q : oldest_q;

  assign do_write  = (state_q == S_WRITE);
  assign tick_next = tick_q + 1'b1;

  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    cmp_vld_d  = 1'b0;
    res_vld_d  = 1'b0;
    tgt_d      = tgt_q;
    oldest_d   = oldest_q;
    success_d  = success_q;
    slot_d     = slot_q;
    found_load = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          success_d = 1'b0;
          slot_d    = '0;
          ptr_d     = '0;
          if (bypass) begin
            res_vld_d = 1'b1;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (rd_en) begin
          ptr_d     = CNT_W'(ptr_q + 1'b1);
          cmp_vld_d = 1'b1;
        end
        if (cmp_vld_q) begin
          if (req_kind_q == KIND_LOOKUP) begin
            if (key_hit) begin
              tgt_d      = cmp_idx_q;
              found_load = 1'b1;
              cmp_vld_d  = 1'b0;
              state_d    = S_WRITE;
            end else if (cmp_idx_q == LAST_IDX) begin
              // Lookup miss: all-zero result, no state change.
              res_vld_d = 1'b1;
              cmp_vld_d = 1'b0;
              state_d   = S_IDLE;
            end
          end else begin
            if (free_or_hit) begin
              tgt_d     = cmp_idx_q;
              cmp_vld_d = 1'b0;
              state_d   = S_WRITE;
            end else begin
              tgt_d    = cand_idx;
              oldest_d = cand_stamp;
              if (cmp_idx_q == LAST_IDX) begin
                cmp_vld_d = 1'b0;
                state_d   = S_WRITE;
              end
            end
          end
        end
      end
      S_WRITE: begin
        success_d = 1'b1;
        slot_d    = SLOT_W'(tgt_q);
        res_vld_d = 1'b1;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      enabled_q <= 1'b1;
      tick_q    <= '0;
      ptr_q     <= '0;
      cmp_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
      for (int i = 0; i < int'(ENTRIES); i++) begin
        valid_q[i] <= 1'b0;
      end
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      cmp_vld_q <= cmp_vld_d;
      res_vld_q <= res_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        enabled_q <= cfg_data_i;
      end
      if (do_write) begin
        tick_q <= tick_next;
        if (req_kind_q == KIND_STORE) begin
          valid_q[tgt_q] <= 1'b1;
        end
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_kind_q     <= kind_i;
      req_key_q      <= entry_key_i;
      req_len_q      <= new_seq_len_i;
      req_dim_q      <= new_dim_i;
      req_handle_q   <= new_handle_i;
      found_len_q    <= '0;
      found_dim_q    <= '0;
      found_handle_q <= '0;
    end else if (found_load) begin
      found_len_q    <= len_rd_q;
      found_dim_q    <= dim_rd_q;
      found_handle_q <= handle_rd_q;
    end
    if (rd_en) begin
      cmp_idx_q <= rd_addr;
      vld_rd_q  <= valid_q[rd_addr];
    end
    tgt_q     <= tgt_d;
    oldest_q  <= oldest_d;
    success_q <= success_d;
    slot_q    <= slot_d;
  end

  // Entry memories: one read port for the scan, one write port for the update.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      key_rd_q    <= key_mem[rd_addr];
      stamp_rd_q  <= stamp_mem[rd_addr];
      len_rd_q    <= len_mem[rd_addr];
      dim_rd_q    <= dim_mem[rd_addr];
      handle_rd_q <= handle_mem[rd_addr];
    end
    if (do_write) begin
      stamp_mem[tgt_q] <= tick_next;
      if (req_kind_q == KIND_STORE) begin
        key_mem[tgt_q]    <= req_key_q;
        len_mem[tgt_q]    <= req_len_q;
        dim_mem[tgt_q]    <= req_dim_q;
        handle_mem[tgt_q] <= req_handle_q;
      end
    end
  end

  assign result_valid_o  = res_vld_q;
  assign success_o       = success_q;
  assign slot_index_o    = slot_q;
  assign found_seq_len_o = found_len_q;
  assign found_dim_o     = found_dim_q;
  assign found_handle_o  = found_handle_q;

  // A result is only presented once the sequencer has released the request channel.
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_vld_q |-> (state_q == S_IDLE))
    else $error("result strobe while the scan is still running");

  // Every accepted request keeps the block busy or produces its result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> (busy || res_vld_q))
    else $error("accepted request neither scanned nor answered");

  // The tick only advances on an entry update.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q != S_WRITE) |=> $stable(tick_q))
    else $error("tick counter moved without an entry update");

  // A failed request reports slot zero and an empty payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (res_vld_q && !success_q) |-> ((slot_q == '0) && (found_len_q == '0) &&
                                                  (found_dim_q == '0) &&
                                                  (found_handle_q == '0)))
    else $error("miss result carries a non-zero slot or payload");

endmodule

`default_nettype wire

// File: bench/lru_keyed_entry_cache_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for lru_keyed_entry_cache_core: a directed table, then random
// lookups and stores over a small key pool, all checked against an in-bench LRU predictor.
// Depends on lkec_pkg and lru_keyed_entry_cache_core; needs no files or arguments.

module lru_keyed_entry_cache_core_tb;

  import lkec_pkg::*;

  localparam int unsigned ENTRIES    = 8;
  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned KEY_POOL   = 16;

  // One result as it appears on the result ports.
  typedef struct packed {
    logic    success;
    slot_t   slot;
    len_t    seq_len;
    dim_t    dim;
    handle_t handle;
  } cache_result_t;

  typedef enum logic {ROW_REQUEST, ROW_CFG_WRITE} row_kind_e;

  // A row of the directed table. A pinned row carries its expected result typed in; every
  // other row is checked against the predictor.
  typedef struct {
    row_kind_e     row;
    logic          cfg_value;
    logic          kind;
    key_t          key;
    len_t          seq_len;
    dim_t          dim;
    handle_t       handle;
    bit            pinned;
    cache_result_t want;
  } dir_row_t;

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  logic    busy;
  logic    kind_i;
  key_t    entry_key_i;
  len_t    new_seq_len_i;
  dim_t    new_dim_i;
  handle_t new_handle_i;
  logic    result_valid_o;
  logic    success_o;
  slot_t   slot_index_o;
  len_t    found_seq_len_o;
  dim_t    found_dim_o;
  handle_t found_handle_o;
  logic    cfg_valid_i;
  logic    cfg_ready_o;
  logic    cfg_data_i;

  // Predictor state: a private copy of the cache contents, the tick and the enable bit.
  logic          line_valid  [ENTRIES];
  key_t          line_key    [ENTRIES];
  stamp_t        line_stamp  [ENTRIES];
  len_t          line_len    [ENTRIES];
  dim_t          line_dim    [ENTRIES];
  handle_t       line_handle [ENTRIES];
  stamp_t        use_tick;
  logic          cache_on;

  cache_result_t pending_results[$];
  dir_row_t      directed_rows[$];
  key_t          key_pool[KEY_POOL];

  // Set by the driver while a pinned request is on the ports; read at acceptance.
  bit            pin_use;
  cache_result_t pin_want;

  bit            steady;
  int unsigned   errors;
  int unsigned   idle_cycles;

  lru_keyed_entry_cache_core #(
    .ENTRIES(ENTRIES)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .entry_key_i    (entry_key_i),
    .new_seq_len_i  (new_seq_len_i),
    .new_dim_i      (new_dim_i),
    .new_handle_i   (new_handle_i),
    .result_valid_o (result_valid_o),
    .success_o      (success_o),
    .slot_index_o   (slot_index_o),
    .found_seq_len_o(found_seq_len_o),
    .found_dim_o    (found_dim_o),
    .found_handle_o (found_handle_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Applies one request to the predictor state and returns the result the block owes.
  // A lookup hit and a written store each take a fresh tick; everything else leaves the
  // state alone and answers with all zeros.
  function automatic cache_result_t predict_access(logic op, key_t key, len_t seq_len,
                                                   dim_t dim, handle_t handle);
    cache_result_t res;
    int            victim;
    bit            found;
    stamp_t        oldest;
    res    = '0;
    victim = 0;
    found  = 1'b0;
    oldest = '0;
    if (!cache_on) return res;
    if (op == KIND_LOOKUP) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (!found && line_valid[i] && line_key[i] == key) begin
          found         = 1'b1;
          use_tick      = use_tick + 1'b1;
          line_stamp[i] = use_tick;
          res.success   = 1'b1;
          res.slot      = slot_t'(i);
          res.seq_len   = line_len[i];
          res.dim       = line_dim[i];
          res.handle    = line_handle[i];
        end
      end
      return res;
    end
    if (seq_len == '0 || dim == '0) return res;
    // A matching or empty entry ends the scan; until then track the oldest stamp, and only
    // a strictly smaller stamp displaces the earlier index.
    for (int i = 0; i < ENTRIES; i++) begin
      if (!found) begin
        if (!line_valid[i] || line_key[i] == key) begin
          victim = i;
          found  = 1'b1;
        end else if (i == 0 || line_stamp[i] < oldest) begin
          oldest = line_stamp[i];
          victim = i;
        end
      end
    end
    line_valid[victim]  = 1'b1;
    line_key[victim]    = key;
    line_len[victim]    = seq_len;
    line_dim[victim]    = dim;
    line_handle[victim] = handle;
    use_tick            = use_tick + 1'b1;
    line_stamp[victim]  = use_tick;
    res.success         = 1'b1;
    res.slot            = slot_t'(victim);
    return res;
  endfunction

  task automatic check_result(cache_result_t want, cache_result_t got);
    if (want.success !== got.success) begin
      $display("%0t: success mismatch: expected %0h, got %0h", $time, want.success, got.success);
      errors++;
    end
    if (want.slot !== got.slot) begin
      $display("%0t: slot_index mismatch: expected %0h, got %0h", $time, want.slot, got.slot);
      errors++;
    end
    if (want.seq_len !== got.seq_len) begin
      $display("%0t: found_seq_len mismatch: expected %0h, got %0h", $time, want.seq_len,
               got.seq_len);
      errors++;
    end
    if (want.dim !== got.dim) begin
      $display("%0t: found_dim mismatch: expected %0h, got %0h", $time, want.dim, got.dim);
      errors++;
    end
    if (want.handle !== got.handle) begin
      $display("%0t: found_handle mismatch: expected %0h, got %0h", $time, want.handle,
               got.handle);
      errors++;
    end
  endtask

  // Everything is sampled at the rising edge, before the block's own registers move. The
  // result of an older request is checked before a request accepted at the same edge is
  // predicted, which keeps the expectations in acceptance order. The watchdog counts edges
  // at which neither a request, a result nor a register write goes through.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o || (start && !busy) || (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (result_valid_o) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result: success %0h slot %0h", $time, success_o,
                   slot_index_o);
          errors++;
        end else begin
          check_result(pending_results.pop_front(), {success_o, slot_index_o,
                       found_seq_len_o, found_dim_o, found_handle_o});
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        cache_on = cfg_data_i;
      end
      if (start && !busy) begin
        cache_result_t predicted;
        predicted = predict_access(kind_i, entry_key_i, new_seq_len_i, new_dim_i,
                                   new_handle_i);
        pending_results.push_back(pin_use ? pin_want : predicted);
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog expired with %0d results outstanding", $time,
                 pending_results.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Presents one request at a falling edge after a random gap and holds it until the block
  // takes it. Start stays high on return, so back-to-back requests never drop it.
  task automatic send_request(logic op, key_t key, len_t seq_len, dim_t dim, handle_t handle,
                              bit pinned, cache_result_t want);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    kind_i        <= op;
    entry_key_i   <= key;
    new_seq_len_i <= seq_len;
    new_dim_i     <= dim;
    new_handle_i  <= handle;
    pin_use        = pinned;
    pin_want       = want;
    start         <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
    pin_use = 1'b0;
  endtask

  // Drops start and holds off until every outstanding request has answered.
  task automatic settle();
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_enable(logic value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_row(row_kind_e row, logic cfg_value, logic op, key_t key, len_t seq_len,
                         dim_t dim, handle_t handle, bit pinned, cache_result_t want);
    dir_row_t r;
    r.row       = row;
    r.cfg_value = cfg_value;
    r.kind      = op;
    r.key       = key;
    r.seq_len   = seq_len;
    r.dim       = dim;
    r.handle    = handle;
    r.pinned    = pinned;
    r.want      = want;
    directed_rows.push_back(r);
  endtask

  // Sizes lean on the zero case, which the block must ignore, and on the all-ones extreme.
  function automatic logic [15:0] pick_size();
    case ($urandom_range(0, 19))
      0: begin
        return '0;
      end
      1: begin
        return '1;
      end
      default: begin
        return 16'($urandom_range(1, 65535));
      end
    endcase
  endfunction

  initial begin
    cache_result_t nothing;
    logic          op;
    key_t          key;
    logic          enable;
    int unsigned   phase_len;
    nothing        = '0;
    errors         = 0;
    idle_cycles    = 0;
    pin_use        = 1'b0;
    pin_want       = '0;
    steady         = 1'b0;
    use_tick       = '0;
    cache_on       = 1'b1;
    for (int i = 0; i < ENTRIES; i++) begin
      line_valid[i]  = 1'b0;
      line_key[i]    = '0;
      line_stamp[i]  = '0;
      line_len[i]    = '0;
      line_dim[i]    = '0;
      line_handle[i] = '0;
    end
    rst_ni        = 1'b0;
    start         = 1'b0;
    kind_i        = KIND_LOOKUP;
    entry_key_i   = '0;
    new_seq_len_i = '0;
    new_dim_i     = '0;
    new_handle_i  = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = 1'b0;

    // The key pool is twice the cache size, so random traffic both hits and evicts.
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom};

    // Directed part. After reset every lookup misses; the first two stores fill the first
    // free entries, then the extreme payloads are read back. Zero length or zero dimension
    // stores are ignored. A store to a resident key overwrites it in place. Eight distinct
    // keys fill the cache, so the next new key evicts the least recently stamped entry.
    // Finally the cache is switched off, where lookups miss and stores do nothing, and on.
    add_row(ROW_REQUEST, 1'b0, KIND_LOOKUP, '0, '0, '0, '0, 1'b1, nothing);
    add_row(ROW_REQUEST, 1'b0, KIND_LOOKUP, '1, '1, '1, '1, 1'b1, nothing);
    add_row(ROW_REQUEST, 1'b0, KIND_STORE, '0, '1, '1, '1, 1'b1,
            {1'b1, 3'd0, 16'h0, 16'h0, 32'h0});
    add_row(ROW_REQUEST, 1'b0, KIND_STORE, '1, 16'd1, 16'd1, '0, 1'b1,
            {1'b1, 3'd1, 16'h0, 16'h0, 32'h0});
    add_row(ROW_REQUEST, 1'b0, KIND_LOOKUP, '0, '0, '0, '0, 1'b1,
            {1'b1, 3'd0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF});
    add_row(ROW_REQUEST, 1'b0, KIND_LOOKUP, '1, '0, '0, '0, 1'b1,
            {1'b1, 3'd1, 16'd1, 16'd1, 32'h0});
    add_row(ROW_REQUEST, 1'b0, KIND_STORE, 64'h55, '0, 16'd5, 32'h1234, 1'b1, nothing);
    add_row(ROW_REQUEST, 1'b0, KIND_STORE, 64'h55, 16'd5, '0, 32'h1234, 1'b1, nothing);
    add_row(ROW_REQUEST, 1'b0, KIND_STORE, '0, 16'h00A5, 16'h5A00, 32'hDEAD_BEEF, 1'b1,
            {1'b1, 3'd0, 16'h0, 16'h0, 32'h0});
    for (int i = 2; i < ENTRIES; i++) begin
      add_row(ROW_REQUEST, 1'b0, KIND_STORE, key_t'(i), 16'(i), 16'(i * 3), 32'(i * 7),
              1'b0, nothing);
    end
    add_row(ROW_REQUEST, 1'b0, KIND_STORE, 64'd100, 16'h8000, 16'h0001, 32'h8000_0001,
            1'b0, nothing);
    add_row(ROW_REQUEST, 1'b0, KIND_LOOKUP, 64'd100, '0, '0, '0, 1'b0, nothing);
    add_row(ROW_REQUEST, 1'b0, KIND_LOOKUP, '1, '0, '0, '0, 1'b0, nothing);
    add_row(ROW_CFG_WRITE, 1'b0, KIND_LOOKUP, '0, '0, '0, '0, 1'b0, nothing);
    add_row(ROW_REQUEST, 1'b0, KIND_LOOKUP, '0, '0, '0, '0, 1'b1, nothing);
    add_row(ROW_REQUEST, 1'b0, KIND_STORE, 64'h55, 16'd3, 16'd3, 32'h3, 1'b1, nothing);
    add_row(ROW_CFG_WRITE, 1'b1, KIND_LOOKUP, '0, '0, '0, '0, 1'b0, nothing);
    add_row(ROW_REQUEST, 1'b0, KIND_LOOKUP, 64'h55, '0, '0, '0, 1'b0, nothing);
    add_row(ROW_REQUEST, 1'b0, KIND_STORE, 64'h55, 16'd3, 16'd3, 32'h3, 1'b0, nothing);
    add_row(ROW_REQUEST, 1'b0, KIND_LOOKUP, '0, '0, '0, '0, 1'b0, nothing);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].row == ROW_CFG_WRITE) begin
        settle();
        write_enable(directed_rows[i].cfg_value);
      end else begin
        send_request(directed_rows[i].kind, directed_rows[i].key, directed_rows[i].seq_len,
                     directed_rows[i].dim, directed_rows[i].handle, directed_rows[i].pinned,
                     directed_rows[i].want);
      end
    end

    // Random part, in phases separated by a drained register write. Two phases run with
    // the cache off and are kept short, and two phases drive requests back to back.
    for (int phase = 0; phase < 9; phase++) begin
      enable    = (phase == 3 || phase == 6) ? 1'b0 : 1'b1;
      phase_len = enable ? 75 : 20;
      steady    = (phase == 2 || phase == 5);
      settle();
      write_enable(enable);
      for (int n = 0; n < phase_len; n++) begin
        op  = $urandom_range(0, 1) ? KIND_STORE : KIND_LOOKUP;
        key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                          : key_pool[$urandom_range(0, KEY_POOL - 1)];
        send_request(op, key, pick_size(), pick_size(), $urandom, 1'b0, nothing);
        // Now and then hold off until the block has answered everything.
        if ($urandom_range(0, 49) == 0) settle();
      end
    end

    settle();
    repeat (ENTRIES + 8) @(posedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
